/* src/dlqc_pkg.sv */
// dlqc_pkg: shared widths, opcodes, register indexes and control structs
// for the dpcm log quantizer codec and packer. No dependencies.
package dlqc_pkg;

	// field widths
	localparam int OP_W       = 2;
	localparam int IDX_W      = 8;
	localparam int ENTRY_W    = 17;
	localparam int SAMPLE_W   = 20;
	localparam int CODE_W     = 8;
	localparam int TAB_W      = 16;
	localparam int PRED_W     = 16;
	localparam int OUT_W      = 32;
	localparam int DIFF_W     = SAMPLE_W + 1;
	localparam int MAG_W      = SAMPLE_W;
	localparam int FRAC_BITS  = 4;
	localparam int RND_W      = MAG_W - FRAC_BITS + 1;
	localparam int CB_W       = 4;
	localparam int LIN_W      = 7;
	localparam int LOG_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// opcodes
	localparam logic [OP_W-1:0] OP_WR_BND = 2'd0;
	localparam logic [OP_W-1:0] OP_WR_DEQ = 2'd1;
	localparam logic [OP_W-1:0] OP_ENCODE = 2'd2;
	localparam logic [OP_W-1:0] OP_DECODE = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CODE_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINEAR    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOG       = 2'd2;

	// register reset values and code width limits
	localparam logic [CB_W-1:0]  CB_MIN    = 4'd2;
	localparam logic [CB_W-1:0]  CB_MAX    = 4'd8;
	localparam logic [CB_W-1:0]  CB_RESET  = 4'd5;
	localparam logic [LIN_W-1:0] LIN_RESET = 7'd4;
	localparam logic [LOG_W-1:0] LOG_RESET = 8'd12;

	// half an lsb of the Q.4 fraction, for rounding
	localparam logic [MAG_W:0] RND_HALF = 21'd8;

	// result kinds
	localparam logic KIND_WORD   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] index;
		logic [TAB_W-1:0] value;
	} tab_wr_t;

	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] mag;
		logic [LOG_W-1:0] limit;
	} scan_req_t;

	typedef struct packed {
		logic             done;
		logic [LOG_W-1:0] idx;
	} scan_rsp_t;

	typedef struct packed {
		logic              push;
		logic [CODE_W-1:0] code;
		logic [CB_W-1:0]   nbits;
		logic              last;
	} pack_req_t;

	typedef struct packed {
		logic             full_vld;
		logic             full_fin;
		logic [OUT_W-1:0] full_word;
		logic             part_vld;
		logic [OUT_W-1:0] part_word;
	} pack_rsp_t;

	// ones in the low n bits, n up to CODE_W
	function automatic logic [CODE_W-1:0] low_mask(input logic [CB_W-1:0] n);
		logic [CODE_W-1:0] m;
		for (int i = 0; i < CODE_W; i++) begin
			m[i] = (CB_W'(i) < n);
		end
		return m;
	endfunction

endpackage

/* src/dlqc_item_if.sv */
// dlqc_item_if: input item channel, valid/ready plus the item fields.
// Depends on dlqc_pkg.
interface dlqc_item_if import dlqc_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [OP_W-1:0]            opcode;
	logic [IDX_W-1:0]           table_index;
	logic signed [ENTRY_W-1:0]  entry_value;
	logic signed [SAMPLE_W-1:0] sample;
	logic [CODE_W-1:0]          code_in;
	logic                       stream_end;

	modport source (output valid, opcode, table_index, entry_value, sample, code_in,
		stream_end, input ready);
	modport sink (input valid, opcode, table_index, entry_value, sample, code_in,
		stream_end, output ready);
endinterface

/* src/dlqc_result_if.sv */
// dlqc_result_if: result channel, valid/ready plus the result fields.
// Depends on dlqc_pkg.
interface dlqc_result_if import dlqc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     result_kind;
	logic [OUT_W-1:0]         packed_word;
	logic signed [PRED_W-1:0] decoded_sample;
	logic                     final_word;

	modport source (output valid, result_kind, packed_word, decoded_sample, final_word,
		input ready);
	modport sink (input valid, result_kind, packed_word, decoded_sample, final_word,
		output ready);
endinterface

/* src/dlqc_cfg_if.sv */
// dlqc_cfg_if: configuration write channel, register index and data.
// Depends on dlqc_pkg.
interface dlqc_cfg_if import dlqc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* src/dlqc_bnd_scan.sv */
// dlqc_bnd_scan: boundary table memory and the sequential boundary search,
// one entry compared per cycle. Depends on dlqc_pkg.
module dlqc_bnd_scan import dlqc_pkg::*; #(
	parameter int BOUNDARY_DEPTH = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	input  tab_wr_t   wr,
	input  scan_req_t req,
	output scan_rsp_t rsp
);

	localparam int               BA_W    = $clog2(BOUNDARY_DEPTH);
	localparam logic [IDX_W:0]   DEPTH_X = (IDX_W + 1)'(BOUNDARY_DEPTH);
	localparam logic [LOG_W-1:0] DEPTH_L = LOG_W'(BOUNDARY_DEPTH);

	logic [TAB_W-1:0] mem [BOUNDARY_DEPTH];
	logic [TAB_W-1:0] rd_s1;
	logic             chk_s1;
	logic [LOG_W-1:0] k_s1;
	logic [LOG_W-1:0] n_q;
	logic [LOG_W-1:0] lim_q;
	logic [MAG_W-1:0] mag_q;
	logic             done_q;
	logic [LOG_W-1:0] idx_q;

	logic [LOG_W-1:0] n_start;
	logic [LOG_W-1:0] k_nxt;
	logic [BA_W-1:0]  rd_addr;
	logic             hit;
	logic             at_end;

	// entries to compare, next address, compare of the entry just read
	always_comb begin
		n_start = (req.limit > DEPTH_L) ? DEPTH_L : req.limit;
		k_nxt   = k_s1 + LOG_W'(1);
		rd_addr = req.start ? '0 : k_nxt[BA_W-1:0];
		hit     = mag_q < MAG_W'(rd_s1);
		at_end  = (k_nxt == n_q);
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr.en && ({1'b0, wr.index} < DEPTH_X)) begin
			mem[wr.index[BA_W-1:0]] <= wr.value;
		end
		rd_s1 <= mem[rd_addr];
	end

	// search control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (n_start == '0) begin
					done_q <= 1'b1;
				end else begin
					chk_s1 <= 1'b1;
				end
			end else if (chk_s1 && (hit || at_end)) begin
				chk_s1 <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// search operands and result index
	always_ff @(posedge clk) begin
		if (req.start) begin
			mag_q <= req.mag;
			lim_q <= req.limit;
			n_q   <= n_start;
			k_s1  <= '0;
			idx_q <= req.limit;
		end else if (chk_s1) begin
			k_s1  <= k_nxt;
			idx_q <= hit ? k_s1 : lim_q;
		end
	end

	assign rsp.done = done_q;
	assign rsp.idx  = idx_q;

	a_done_follows_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(req.start || chk_s1))
		else $error("boundary search done without a search in flight");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (idx_q <= lim_q))
		else $error("boundary index beyond the log level limit");

endmodule

/* src/dlqc_recon.sv */
// dlqc_recon: dequantization table memory and the predictor that sums the
// dequantized values. Depends on dlqc_pkg.
module dlqc_recon import dlqc_pkg::*; #(
	parameter int DEQUANT_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tab_wr_t           wr,
	input  logic              rd_req,
	input  logic [CODE_W-1:0] rd_code,
	output logic [PRED_W-1:0] predictor
);

	localparam int             DA_W    = $clog2(DEQUANT_DEPTH);
	localparam logic [IDX_W:0] DEPTH_X = (IDX_W + 1)'(DEQUANT_DEPTH);

	logic [TAB_W-1:0]  mem [DEQUANT_DEPTH];
	logic [TAB_W-1:0]  rd_s1;
	logic              inr_s1;
	logic              pend_s1;
	logic [PRED_W-1:0] pred_q;

	// table memory; codes past the depth read as zero
	always_ff @(posedge clk) begin
		if (wr.en && ({1'b0, wr.index} < DEPTH_X)) begin
			mem[wr.index[DA_W-1:0]] <= wr.value;
		end
		rd_s1  <= mem[rd_code[DA_W-1:0]];
		inr_s1 <= ({1'b0, rd_code} < DEPTH_X);
	end

	// predictor accumulate, wraps at 16 bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
			pred_q  <= '0;
		end else begin
			pend_s1 <= rd_req;
			if (pend_s1) begin
				pred_q <= pred_q + (inr_s1 ? rd_s1 : '0);
			end
		end
	end

	assign predictor = pred_q;

	a_pred_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		!pend_s1 |=> $stable(pred_q))
		else $error("predictor moved without a dequant read");

endmodule

/* src/dlqc_packer.sv */
// dlqc_packer: lsb-first code packer with the full word and the flushed
// partial word of the last push held for emission. Depends on dlqc_pkg.
module dlqc_packer import dlqc_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  pack_req_t req,
	output pack_rsp_t rsp
);

	localparam int CW   = WORD_BITS + CODE_W;
	localparam int BP_W = $clog2(CW);
	localparam int WX   = (WORD_BITS > OUT_W) ? WORD_BITS : OUT_W;

	logic [WORD_BITS-1:0] buf_q;
	logic [BP_W-1:0]      bp_q;
	logic                 full_vld_q;
	logic                 full_fin_q;
	logic                 part_vld_q;
	logic [OUT_W-1:0]     full_word_q;
	logic [OUT_W-1:0]     part_word_q;

	logic [CW-1:0]        merged;
	logic [BP_W-1:0]      bp_sum;
	logic                 full;
	logic [BP_W-1:0]      bp_next;
	logic [WORD_BITS-1:0] buf_next;
	logic [WX-1:0]        full_x;
	logic [WX-1:0]        part_x;

	// merge the code at the bit position, spill past the word boundary
	always_comb begin
		merged   = CW'(buf_q) | (CW'(req.code) << bp_q);
		bp_sum   = bp_q + BP_W'(req.nbits);
		full     = bp_sum >= BP_W'(WORD_BITS);
		bp_next  = full ? (bp_sum - BP_W'(WORD_BITS)) : bp_sum;
		buf_next = full ? WORD_BITS'(merged[CW-1:WORD_BITS]) : merged[WORD_BITS-1:0];
		full_x   = WX'(merged[WORD_BITS-1:0]);
		part_x   = WX'(buf_next);
	end

	// pack state and word flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q      <= '0;
			bp_q       <= '0;
			full_vld_q <= 1'b0;
			full_fin_q <= 1'b0;
			part_vld_q <= 1'b0;
		end else if (req.push) begin
			full_vld_q <= full;
			full_fin_q <= req.last && (bp_next == '0);
			part_vld_q <= req.last && (bp_next != '0);
			buf_q      <= req.last ? '0 : buf_next;
			bp_q       <= req.last ? '0 : bp_next;
		end
	end

	// word payload
	always_ff @(posedge clk) begin
		if (req.push) begin
			full_word_q <= full_x[OUT_W-1:0];
			part_word_q <= part_x[OUT_W-1:0];
		end
	end

	assign rsp.full_vld  = full_vld_q;
	assign rsp.full_fin  = full_fin_q;
	assign rsp.full_word = full_word_q;
	assign rsp.part_vld  = part_vld_q;
	assign rsp.part_word = part_word_q;

	a_bp_below_word: assert property (@(posedge clk) disable iff (!arst_n)
		bp_q < BP_W'(WORD_BITS))
		else $error("bit position reached the word size");

	a_last_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		req.push && req.last |=> (full_vld_q || part_vld_q) && (bp_q == '0))
		else $error("stream end left no word or left bits behind");

endmodule

/* src/dpcm_log_quant_codec_packer_unit.sv */
// dpcm_log_quant_codec_packer_unit: dpcm codec top, sequencer, config and
// result register. Depends on dlqc_pkg, the dlqc interfaces and submodules.
// Sequence: a table write gives no result; a decode goes through S_DEQ_RD to
// S_EMIT_A; an encode goes through S_DIFF, S_QNT, in the log zone S_SCAN, then
// S_PUSH, S_DEQ_RD and the emit states, one boundary entry per memory read.
// Throughput: one item in flight; next item taken once its results are loaded.
// Reset: code_bits 5, linear_levels 4, log_levels 12, predictor and packer
// cleared, stream start set; table memories are not cleared.
module dpcm_log_quant_codec_packer_unit import dlqc_pkg::*; #(
	parameter int DEQUANT_DEPTH  = 256,
	parameter int BOUNDARY_DEPTH = 128,
	parameter int WORD_BITS      = 32
) (
	input logic           clk,
	input logic           arst_n,
	dlqc_item_if.sink     item,
	dlqc_result_if.source result,
	dlqc_cfg_if.sink      cfg
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DIFF   = 3'd1;
	localparam logic [2:0] S_QNT    = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_PUSH   = 3'd4;
	localparam logic [2:0] S_DEQ_RD = 3'd5;
	localparam logic [2:0] S_EMIT_A = 3'd6;
	localparam logic [2:0] S_EMIT_B = 3'd7;

	logic [2:0]                 state_q;
	logic [CB_W-1:0]            code_bits_q;
	logic [LIN_W-1:0]           lin_q;
	logic [LOG_W-1:0]           log_q;
	logic                       start_q;
	logic signed [SAMPLE_W-1:0] smp_q;
	logic                       last_q;
	logic                       dec_q;
	logic                       neg_q;
	logic [MAG_W-1:0]           mag_q;
	logic [CODE_W-1:0]          code_q;

	logic                       out_vld_q;
	logic                       out_kind_q;
	logic [OUT_W-1:0]           out_word_q;
	logic [PRED_W-1:0]          out_dec_q;
	logic                       out_fin_q;

	logic                       in_acc;
	logic [CB_W-1:0]            cb;
	logic signed [DIFF_W-1:0]   smp_x;
	logic signed [DIFF_W-1:0]   pred_x;
	logic signed [DIFF_W-1:0]   diff;
	logic [DIFF_W-1:0]          diff_abs;
	logic [MAG_W:0]             rnd;
	logic [RND_W-1:0]           r;
	logic                       lin_hit;
	logic                       can_load;
	logic                       load;
	logic [PRED_W-1:0]          predictor;

	tab_wr_t                    bnd_wr;
	tab_wr_t                    deq_wr;
	scan_req_t                  scan_req;
	scan_rsp_t                  scan_rsp;
	pack_req_t                  pk_req;
	pack_rsp_t                  pk_rsp;
	logic                       deq_req;
	logic [CODE_W-1:0]          deq_code;

	// sign/magnitude code from a magnitude and the sign of the difference
	function automatic logic [CODE_W-1:0] make_code(input logic [CODE_W-1:0] m,
		input logic neg, input logic [CB_W-1:0] nbits);
		logic [CODE_W-1:0] mm;
		mm = low_mask(nbits - CB_W'(1));
		return (m & mm) | (neg ? (mm + CODE_W'(1)) : '0);
	endfunction

	assign in_acc     = item.valid && item.ready;
	assign item.ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;

	// effective code width
	always_comb begin
		priority if (code_bits_q < CB_MIN) begin
			cb = CB_MIN;
		end else if (code_bits_q > CB_MAX) begin
			cb = CB_MAX;
		end else begin
			cb = code_bits_q;
		end
	end

	// difference from the predictor and its rounded magnitude
	always_comb begin
		smp_x    = DIFF_W'(smp_q);
		pred_x   = DIFF_W'($signed({predictor, FRAC_BITS'(0)}));
		diff     = smp_x - pred_x;
		diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		rnd      = (MAG_W + 1)'(mag_q) + RND_HALF;
		r        = rnd[MAG_W:FRAC_BITS];
		lin_hit  = r < RND_W'(lin_q);
	end

	// table writes, search start, dequant read and packer push
	always_comb begin
		bnd_wr.en       = in_acc && (item.opcode == OP_WR_BND);
		bnd_wr.index    = item.table_index;
		bnd_wr.value    = item.entry_value[TAB_W-1:0];
		deq_wr.en       = in_acc && (item.opcode == OP_WR_DEQ);
		deq_wr.index    = item.table_index;
		deq_wr.value    = item.entry_value[TAB_W-1:0];

		scan_req.start  = (state_q == S_QNT) && !lin_hit;
		scan_req.mag    = mag_q;
		scan_req.limit  = (log_q > LOG_W'(1)) ? (log_q - LOG_W'(1)) : '0;

		deq_req         = (in_acc && (item.opcode == OP_DECODE)) || (state_q == S_PUSH);
		deq_code        = (state_q == S_PUSH) ? code_q : (item.code_in & low_mask(cb));

		pk_req.push     = (state_q == S_PUSH);
		pk_req.code     = code_q;
		pk_req.nbits    = cb;
		pk_req.last     = last_q;
	end

	assign can_load = !out_vld_q || result.ready;
	assign load     = can_load && ((state_q == S_EMIT_A) || (state_q == S_EMIT_B));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_bits_q <= CB_RESET;
			lin_q       <= LIN_RESET;
			log_q       <= LOG_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_CODE_BITS: code_bits_q <= cfg.data[CB_W-1:0];
				REG_LINEAR:    lin_q       <= cfg.data[LIN_W-1:0];
				REG_LOG:       log_q       <= cfg.data[LOG_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && (item.opcode == OP_ENCODE)) begin
						state_q <= S_DIFF;
						start_q <= item.stream_end;
					end else if (in_acc && (item.opcode == OP_DECODE)) begin
						state_q <= S_DEQ_RD;
					end
				end
				S_DIFF: state_q <= S_QNT;
				S_QNT:  state_q <= lin_hit ? S_PUSH : S_SCAN;
				S_SCAN: begin
					if (scan_rsp.done) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: state_q <= S_DEQ_RD;
				S_DEQ_RD: begin
					if (dec_q || pk_rsp.full_vld) begin
						state_q <= S_EMIT_A;
					end else if (pk_rsp.part_vld) begin
						state_q <= S_EMIT_B;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT_A: begin
					if (can_load) begin
						state_q <= (!dec_q && pk_rsp.part_vld) ? S_EMIT_B : S_IDLE;
					end
				end
				S_EMIT_B: begin
					if (can_load) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	// item operands and the code under way
	always_ff @(posedge clk) begin
		if (in_acc) begin
			smp_q  <= start_q ? '0 : item.sample;
			last_q <= item.stream_end;
			dec_q  <= (item.opcode == OP_DECODE);
		end
		if (state_q == S_DIFF) begin
			neg_q <= diff[DIFF_W-1];
			mag_q <= diff_abs[MAG_W-1:0];
		end
		if ((state_q == S_QNT) && lin_hit) begin
			code_q <= make_code(r[CODE_W-1:0], neg_q, cb);
		end else if ((state_q == S_SCAN) && scan_rsp.done) begin
			code_q <= make_code(CODE_W'(LOG_W'(lin_q) + scan_rsp.idx), neg_q, cb);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			if ((state_q == S_EMIT_A) && dec_q) begin
				out_kind_q <= KIND_SAMPLE;
				out_word_q <= '0;
				out_dec_q  <= predictor;
				out_fin_q  <= 1'b0;
			end else if (state_q == S_EMIT_A) begin
				out_kind_q <= KIND_WORD;
				out_word_q <= pk_rsp.full_word;
				out_dec_q  <= '0;
				out_fin_q  <= pk_rsp.full_fin;
			end else begin
				out_kind_q <= KIND_WORD;
				out_word_q <= pk_rsp.part_word;
				out_dec_q  <= '0;
				out_fin_q  <= 1'b1;
			end
		end
	end

	assign result.valid          = out_vld_q;
	assign result.result_kind    = out_kind_q;
	assign result.packed_word    = out_word_q;
	assign result.decoded_sample = out_dec_q;
	assign result.final_word     = out_fin_q;

	dlqc_bnd_scan #(
		.BOUNDARY_DEPTH(BOUNDARY_DEPTH)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (bnd_wr),
		.req   (scan_req),
		.rsp   (scan_rsp)
	);

	dlqc_recon #(
		.DEQUANT_DEPTH(DEQUANT_DEPTH)
	) u_recon (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (deq_wr),
		.rd_req   (deq_req),
		.rd_code  (deq_code),
		.predictor(predictor)
	);

	dlqc_packer #(
		.WORD_BITS(WORD_BITS)
	) u_packer (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (pk_req),
		.rsp   (pk_rsp)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load && out_vld_q |-> result.ready)
		else $error("result register overwritten before its beat was taken");

	a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_rsp.done |-> (state_q == S_SCAN))
		else $error("boundary search finished outside the search state");

	a_decode_reads: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (item.opcode == OP_DECODE) |=> (state_q == S_DEQ_RD))
		else $error("decode beat did not start a dequant read");

endmodule
